@@ sv/dmrl_pkg.sv @@
// ----------------------------------------------------------------------------
// dmrl_pkg - shared types and constants for the max read latency block
// Field widths, pipeline stage records, the memory-clock divisor function and the
// reciprocal table used for the ceiling division.
// ----------------------------------------------------------------------------
package dmrl_pkg;

   // field widths
   localparam int CAS_W     = 4;
   localparam int RP_W      = 4;
   localparam int RCV_W     = 8;
   localparam int FREQ_W    = 3;
   localparam int NBM_W     = 5;
   localparam int START_W   = 10;
   localparam int MARGIN_W  = 6;

   // internal widths
   localparam int HALF_W    = 6;                   // half-clock sum, max 51
   localparam int F_W       = 7;                   // scaled multiplier, max 105
   localparam int PROD_W    = 13;                  // f * half, max 5355
   localparam int X_W       = PROD_W + 1;          // rounded numerator, max 10749
   localparam int XM_W      = F_W + 2;             // margin numerator, max 459
   localparam int DIV_W     = 6;                   // divisor, 12 to 40
   localparam int RECIP_SHIFT = 20;                // X_W plus divisor bits
   localparam int RECIP_W   = 17;
   localparam int PRODL_W   = X_W + RECIP_W;
   localparam int PRODM_W   = XM_W + RECIP_W;

   // constants of the latency formula
   localparam logic [RP_W-1:0]   RP_MAX         = 4'd8;
   localparam logic [F_W-1:0]    NB_OFFSET      = 7'd4;
   localparam logic [DIV_W-1:0]  DIV_OFFSET     = 6'd12;
   localparam logic [FREQ_W-1:0] MCLK_CODE_ALIAS  = 3'd4;
   localparam logic [FREQ_W-1:0] MCLK_CODE_TARGET = 3'd5;

   // ceil(2^RECIP_SHIFT / d) per divisor, exact floor for numerators below 2^X_W
   localparam int R12 = ((1 << RECIP_SHIFT) + 11) / 12;
   localparam int R16 = ((1 << RECIP_SHIFT) + 15) / 16;
   localparam int R20 = ((1 << RECIP_SHIFT) + 19) / 20;
   localparam int R24 = ((1 << RECIP_SHIFT) + 23) / 24;
   localparam int R32 = ((1 << RECIP_SHIFT) + 31) / 32;
   localparam int R36 = ((1 << RECIP_SHIFT) + 35) / 36;
   localparam int R40 = ((1 << RECIP_SHIFT) + 39) / 40;

   // indexed by memory clock code; the aliased code shares its target's entry
   localparam logic [RECIP_W-1:0] RECIP_TABLE [8] = '{
      RECIP_W'(R12), RECIP_W'(R16), RECIP_W'(R20), RECIP_W'(R24),
      RECIP_W'(R32), RECIP_W'(R32), RECIP_W'(R36), RECIP_W'(R40)
   };

   // input transaction payload
   typedef struct packed {
      logic [CAS_W-1:0]  cas_field;
      logic              registered_dimm;
      logic              setup_full_clock;
      logic [RP_W-1:0]   read_pointer_init;
      logic [RCV_W-1:0]  receiver_enable_delay;
      logic [FREQ_W-1:0] mem_clock_freq;
   } req_fields_type;

   // first stage: half-clock sum and scaled multiplier
   typedef struct packed {
      logic [HALF_W-1:0] half;
      logic [F_W-1:0]    f;
      logic [FREQ_W-1:0] freq;
      logic              clamped;
   } sum_type;

   // second stage: product of sum and multiplier
   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [F_W-1:0]    f;
      logic [FREQ_W-1:0] freq;
      logic              clamped;
   } scale_type;

   // result transaction payload
   typedef struct packed {
      logic [START_W-1:0]  start_latency;
      logic [MARGIN_W-1:0] margin;
      logic                read_pointer_clamped;
   } rsp_fields_type;

   // memory clock divisor 4 * (code + 3)
   function automatic logic [DIV_W-1:0] mclk_divisor(input logic [FREQ_W-1:0] code);
      return DIV_W'({code, 2'b00}) + DIV_OFFSET;
   endfunction

endpackage

@@ sv/dmrl_req_if.sv @@
// ----------------------------------------------------------------------------
// dmrl_req_if - request channel
// Valid/ready handshake carrying one latency query per transaction.
// ----------------------------------------------------------------------------
interface dmrl_req_if import dmrl_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CAS_W-1:0]  cas_field;
   logic              registered_dimm;
   logic              setup_full_clock;
   logic [RP_W-1:0]   read_pointer_init;
   logic [RCV_W-1:0]  receiver_enable_delay;
   logic [FREQ_W-1:0] mem_clock_freq;

   modport source (
      output valid, cas_field, registered_dimm, setup_full_clock,
             read_pointer_init, receiver_enable_delay, mem_clock_freq,
      input  ready
   );

   modport sink (
      input  valid, cas_field, registered_dimm, setup_full_clock,
             read_pointer_init, receiver_enable_delay, mem_clock_freq,
      output ready
   );
endinterface

@@ sv/dmrl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dmrl_rsp_if - response channel
// Valid/ready handshake carrying one latency result per transaction.
// ----------------------------------------------------------------------------
interface dmrl_rsp_if import dmrl_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [START_W-1:0]  start_latency;
   logic [MARGIN_W-1:0] margin;
   logic                read_pointer_clamped;

   modport source (
      output valid, start_latency, margin, read_pointer_clamped,
      input  ready
   );

   modport sink (
      input  valid, start_latency, margin, read_pointer_clamped,
      output ready
   );
endinterface

@@ sv/dram_max_read_latency_start.sv @@
// Throughput: one transaction per cycle unless the response stalls; the
// five-stage valid/ready pipeline holds up to five transactions and stalls stage by stage from the response.
// Reset clears all stage valid bits and the nb_multiplier register to zero.
// ----------------------------------------------------------------------------
// dram_max_read_latency_start - starting maximum read latency
// Sums the read latency in half memory clocks, scales it to northbridge
// clocks and rounds up, together with a one memory clock margin.
// ----------------------------------------------------------------------------
module dram_max_read_latency_start import dmrl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [NBM_W-1:0]  csr_wr_data,
   dmrl_req_if.sink          req,
   dmrl_rsp_if.source        rsp
);

   logic [NBM_W-1:0] nb_multiplier_ff;
   req_fields_type   req_data;
   scale_type        mid_data;
   logic             mid_valid;
   logic             mid_ready;
   rsp_fields_type   rsp_data;

   // northbridge multiplier register
   always_ff @(posedge clock) begin
      if (reset) begin
         nb_multiplier_ff <= '0;
      end else if (csr_wr_en) begin
         nb_multiplier_ff <= csr_wr_data;
      end
   end

   // request payload
   always_comb begin
      req_data.cas_field             = req.cas_field;
      req_data.registered_dimm       = req.registered_dimm;
      req_data.setup_full_clock      = req.setup_full_clock;
      req_data.read_pointer_init     = req.read_pointer_init;
      req_data.receiver_enable_delay = req.receiver_enable_delay;
      req_data.mem_clock_freq        = req.mem_clock_freq;
   end

   dmrl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .nb_multiplier (nb_multiplier_ff),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_data       (req_data),
      .out_valid     (mid_valid),
      .out_ready     (mid_ready),
      .out_data      (mid_data)
   );

   dmrl_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

   // response payload
   assign rsp.start_latency        = rsp_data.start_latency;
   assign rsp.margin               = rsp_data.margin;
   assign rsp.read_pointer_clamped = rsp_data.read_pointer_clamped;

`ifndef NO_ASSERTIONS
   // an empty output stage means nothing in the pipe can block a request
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("request not ready while output stage is empty");

   // margin stays within what the smallest and largest ratios allow
   a_margin_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.margin >= MARGIN_W'(2) && rsp.margin <= MARGIN_W'(36)))
      else $error("margin out of range");

   // a register write lands in the multiplier register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> nb_multiplier_ff == $past(csr_wr_data))
      else $error("nb_multiplier write lost");
`endif

endmodule

@@ sv/dmrl_front.sv @@
// ----------------------------------------------------------------------------
// dmrl_front - latency sum and northbridge scaling
// Two pipeline stages: sum of the half-clock terms, then the product with
// the scaled northbridge multiplier.
// ----------------------------------------------------------------------------
module dmrl_front import dmrl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [NBM_W-1:0]   nb_multiplier,
   input  logic               in_valid,
   output logic               in_ready,
   input  req_fields_type     in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output scale_type          out_data
);

   logic      a_valid_ff;
   logic      b_valid_ff;
   logic      a_adv;
   logic      b_adv;
   sum_type   a_ff;
   sum_type   a_in;
   scale_type b_ff;
   scale_type b_in;

   // stage advance chain
   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   // half-clock sum, read pointer clamp, frequency alias, multiplier scale
   always_comb begin
      logic [HALF_W-1:0] rp_term;
      logic [F_W-1:0]    nb_ext;
      a_in.clamped = (in_data.read_pointer_init > RP_MAX);
      rp_term      = a_in.clamped ? '0 : HALF_W'(RP_MAX - in_data.read_pointer_init);
      a_in.half    = HALF_W'({in_data.cas_field, 1'b0}) + HALF_W'(2)
                   + (in_data.registered_dimm ? HALF_W'(2) : HALF_W'(0))
                   + (in_data.setup_full_clock ? HALF_W'(2) : HALF_W'(1))
                   + rp_term
                   + HALF_W'(in_data.receiver_enable_delay[RCV_W-1 -: 3]);
      a_in.freq    = (in_data.mem_clock_freq == MCLK_CODE_ALIAS) ?
                     MCLK_CODE_TARGET : in_data.mem_clock_freq;
      nb_ext       = F_W'(nb_multiplier) + NB_OFFSET;
      a_in.f       = (nb_ext << 1) + nb_ext;
   end

   // product of sum and scaled multiplier
   always_comb begin
      b_in.prod    = PROD_W'(a_ff.half) * PROD_W'(a_ff.f);
      b_in.f       = a_ff.f;
      b_in.freq    = a_ff.freq;
      b_in.clamped = a_ff.clamped;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= in_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (a_adv && in_valid) begin
         a_ff <= a_in;
      end
      if (b_adv && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

@@ sv/dmrl_conv.sv @@
// ----------------------------------------------------------------------------
// dmrl_conv - ceiling division by the memory clock divisor
// Three pipeline stages: rounding offset and reciprocal lookup, reciprocal
// multiply, then the output register with the margin increment.
// ----------------------------------------------------------------------------
module dmrl_conv import dmrl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  scale_type       in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_fields_type  out_data
);

   typedef struct packed {
      logic [X_W-1:0]     x;
      logic [XM_W-1:0]    xm;
      logic [RECIP_W-1:0] recip;
      logic               clamped;
   } round_type;

   typedef struct packed {
      logic [START_W-1:0]  q;
      logic [MARGIN_W-1:0] qm;
      logic                clamped;
   } quot_type;

   logic           c_valid_ff;
   logic           d_valid_ff;
   logic           e_valid_ff;
   logic           c_adv;
   logic           d_adv;
   logic           e_adv;
   round_type      c_ff;
   round_type      c_in;
   quot_type       d_ff;
   quot_type       d_in;
   rsp_fields_type e_ff;
   rsp_fields_type e_in;

   // stage advance chain
   assign e_adv    = !e_valid_ff || out_ready;
   assign d_adv    = !d_valid_ff || e_adv;
   assign c_adv    = !c_valid_ff || d_adv;
   assign in_ready = c_adv;

   // add divisor minus one for rounding up, fetch reciprocal
   always_comb begin
      logic [DIV_W-1:0] div;
      div          = mclk_divisor(in_data.freq);
      c_in.x       = {in_data.prod, 1'b0} + X_W'(div) - X_W'(1);
      c_in.xm      = {in_data.f, 2'b00} + XM_W'(div) - XM_W'(1);
      c_in.recip   = RECIP_TABLE[in_data.freq];
      c_in.clamped = in_data.clamped;
   end

   // quotients by reciprocal multiply
   always_comb begin
      logic [PRODL_W-1:0] pl;
      logic [PRODM_W-1:0] pm;
      pl           = PRODL_W'(c_ff.x) * PRODL_W'(c_ff.recip);
      pm           = PRODM_W'(c_ff.xm) * PRODM_W'(c_ff.recip);
      d_in.q       = pl[RECIP_SHIFT +: START_W];
      d_in.qm      = pm[RECIP_SHIFT +: MARGIN_W];
      d_in.clamped = c_ff.clamped;
   end

   // result fields
   always_comb begin
      e_in.start_latency        = d_ff.q;
      e_in.margin               = d_ff.qm + MARGIN_W'(1);
      e_in.read_pointer_clamped = d_ff.clamped;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_adv) begin
            c_valid_ff <= in_valid;
         end
         if (d_adv) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_adv) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (c_adv && in_valid) begin
         c_ff <= c_in;
      end
      if (d_adv && c_valid_ff) begin
         d_ff <= d_in;
      end
      if (e_adv && d_valid_ff) begin
         e_ff <= e_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_ff;

endmodule

@@ sim/dram_max_read_latency_start_tb.sv @@
// ----------------------------------------------------------------------------
// dram_max_read_latency_start_tb - self-checking bench for the latency block
// Drives latency queries over the request channel: first a table of corner
// cases, then random queries under several nb_multiplier settings, with
// random idling on both channels and one long response hold-off. Every
// response transaction is compared field by field, in order, with the typed-in
// answer of its corner case or with a behavioral prediction.
// ----------------------------------------------------------------------------
module dram_max_read_latency_start_tb;
   import dmrl_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASES        = 8;
   localparam int PHASE_QUERIES = 190;
   localparam int HOLD_CYCLES   = 120;
   localparam int DRAIN_CYCLES  = 10;

   // one corner-case row: query, whether the answer is typed in, the answer
   typedef struct packed {
      req_fields_type query;
      logic           known;
      rsp_fields_type answer;
   } probe_row_type;

   localparam int PROBE_ROWS = 20;

   // corner cases at the reset setting of nb_multiplier (scale 12)
   // fields: cas, registered, setup, read pointer, receiver delay, frequency
   localparam probe_row_type PROBES [PROBE_ROWS] = '{
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd0}, 1'b1, '{10'd22,  6'd5, 1'b0}},
      '{'{4'd15, 1'b1, 1'b1, 4'd0,  8'hff, 3'd0}, 1'b1, '{10'd102, 6'd5, 1'b0}},
      '{'{4'd0,  1'b0, 1'b0, 4'd15, 8'h00, 3'd0}, 1'b1, '{10'd6,   6'd5, 1'b1}},
      '{'{4'd0,  1'b0, 1'b0, 4'd8,  8'h00, 3'd0}, 1'b1, '{10'd6,   6'd5, 1'b0}},
      '{'{4'd0,  1'b0, 1'b0, 4'd9,  8'h00, 3'd0}, 1'b1, '{10'd6,   6'd5, 1'b1}},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd7}, 1'b1, '{10'd7,   6'd3, 1'b0}},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd4}, 1'b1, '{10'd9,   6'd3, 1'b0}},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd5}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd1}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd2}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd3}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h00, 3'd6}, 1'b0, '0},
      '{'{4'd0,  1'b1, 1'b0, 4'd0,  8'h00, 3'd2}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b1, 4'd0,  8'h00, 3'd3}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h1f, 3'd1}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'h20, 3'd1}, 1'b0, '0},
      '{'{4'd0,  1'b0, 1'b0, 4'd0,  8'he0, 3'd6}, 1'b0, '0},
      '{'{4'd15, 1'b0, 1'b0, 4'd7,  8'h00, 3'd4}, 1'b0, '0},
      '{'{4'd15, 1'b1, 1'b1, 4'd0,  8'hff, 3'd7}, 1'b0, '0},
      '{'{4'd15, 1'b1, 1'b1, 4'd15, 8'hff, 3'd7}, 1'b0, '0}
   };

   // idle percentage per random phase; the last phase runs without idling
   localparam int IDLE_PLAN [PHASES] = '{20, 25, 0, 35, 10, 50, 15, 0};

   logic clock;
   logic reset = 1'b1;
   logic              csr_wr_en;
   logic [NBM_W-1:0]  csr_wr_data;

   dmrl_req_if req ();
   dmrl_rsp_if rsp ();

   dram_max_read_latency_start uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req.sink),
      .rsp         (rsp.source)
   );

   rsp_fields_type    latency_q [$];
   logic [NBM_W-1:0]  nb_setting = '0;
   int unsigned       idle_pct = 20;
   bit                hold_off_pending = 1'b0;
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;

   // latency, margin and clamp flag for one query at a given multiplier
   function automatic rsp_fields_type predict_latency(input req_fields_type q,
                                                      input logic [NBM_W-1:0] nbm);
      int unsigned    half;
      int unsigned    code;
      int unsigned    divisor;
      int unsigned    scale;
      rsp_fields_type r;
      half = (int'(q.cas_field) + 1) * 2;
      half += q.registered_dimm ? 2 : 0;
      half += q.setup_full_clock ? 2 : 1;
      r.read_pointer_clamped = (q.read_pointer_init > 4'd8);
      if (!r.read_pointer_clamped) begin
         half += 8 - int'(q.read_pointer_init);
      end
      half += int'(q.receiver_enable_delay[7:5]);
      code = (q.mem_clock_freq == 3'd4) ? 5 : int'(q.mem_clock_freq);
      divisor = 4 * (code + 3);
      scale = (int'(nbm) + 4) * 3;
      r.start_latency = START_W'((scale * 2 * half + divisor - 1) / divisor);
      r.margin = MARGIN_W'((4 * scale + divisor - 1) / divisor + 1);
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dram_max_read_latency_start_tb: done, errors");
         $finish;
      end
   end

   // offer one query, wait for its handshake, record the expected answer
   task automatic send_query(input req_fields_type q, input rsp_fields_type answer);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req.valid                 <= 1'b1;
      req.cas_field             <= q.cas_field;
      req.registered_dimm       <= q.registered_dimm;
      req.setup_full_clock      <= q.setup_full_clock;
      req.read_pointer_init     <= q.read_pointer_init;
      req.receiver_enable_delay <= q.receiver_enable_delay;
      req.mem_clock_freq        <= q.mem_clock_freq;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      latency_q.push_back(answer);
   endtask

   // write the multiplier once the pipeline has drained
   task automatic set_nb_multiplier(input logic [NBM_W-1:0] value);
      req.valid <= 1'b0;
      while (latency_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      nb_setting = value;
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      req_fields_type   q;
      logic [NBM_W-1:0] nbm;
      req.valid                 <= 1'b0;
      req.cas_field             <= '0;
      req.registered_dimm       <= 1'b0;
      req.setup_full_clock      <= 1'b0;
      req.read_pointer_init     <= '0;
      req.receiver_enable_delay <= '0;
      req.mem_clock_freq        <= '0;
      csr_wr_en                 <= 1'b0;
      csr_wr_data               <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner-case table at the reset setting
      foreach (PROBES[i]) begin
         send_query(PROBES[i].query, PROBES[i].known ? PROBES[i].answer
                                                     : predict_latency(PROBES[i].query,
                                                                       nb_setting));
      end

      // random phases, each under its own multiplier
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: nbm = 5'd31;
            1: nbm = 5'd0;
            2: nbm = 5'd1;
            3: nbm = 5'd30;
            default: nbm = NBM_W'($urandom_range(0, 31));
         endcase
         set_nb_multiplier(nbm);
         idle_pct = IDLE_PLAN[p];
         if (p == 1) begin
            hold_off_pending = 1'b1;
         end
         // largest sum first, then random content
         q = '{4'd15, 1'b1, 1'b1, 4'd0, 8'hff, 3'($urandom_range(0, 7))};
         send_query(q, predict_latency(q, nb_setting));
         repeat (PHASE_QUERIES) begin
            q = req_fields_type'($urandom);
            send_query(q, predict_latency(q, nb_setting));
         end
      end

      // drain and report
      req.valid <= 1'b0;
      while (latency_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("dram_max_read_latency_start_tb: done, clean");
      end else begin
         $display("dram_max_read_latency_start_tb: done, errors");
      end
      $finish;
   end

   // response side backpressure: random bursts and one long hold-off
   initial begin
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_pending) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_pending = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_fields_type exp_rsp;
      if (!reset && rsp.valid && rsp.ready) begin
         if (latency_q.size() == 0) begin
            $display("%0t: unexpected response, latency %0d margin %0d clamped %0d",
                     $time, rsp.start_latency, rsp.margin, rsp.read_pointer_clamped);
            mismatches++;
         end else begin
            exp_rsp = latency_q.pop_front();
            if (rsp.start_latency !== exp_rsp.start_latency) begin
               $display("%0t: start_latency expected %0d actual %0d",
                        $time, exp_rsp.start_latency, rsp.start_latency);
               mismatches++;
            end
            if (rsp.margin !== exp_rsp.margin) begin
               $display("%0t: margin expected %0d actual %0d",
                        $time, exp_rsp.margin, rsp.margin);
               mismatches++;
            end
            if (rsp.read_pointer_clamped !== exp_rsp.read_pointer_clamped) begin
               $display("%0t: read_pointer_clamped expected %0d actual %0d",
                        $time, exp_rsp.read_pointer_clamped, rsp.read_pointer_clamped);
               mismatches++;
            end
         end
      end
   end

endmodule
